>>> sv/sbg_pkg.sv
// Shared types, register codes, constants and saturation helper of the sheath boundary guard cell.
package sbg_pkg;

   // Extrapolation mode codes; bit 1 set selects the linear form.
   localparam logic [1:0] MODE_LIMITED = 2'd0;
   localparam logic [1:0] MODE_EXP     = 2'd1;
   localparam logic [1:0] MODE_LINEAR  = 2'd2;
   localparam int         LINEAR_BIT   = 1;

   // Configuration register indexes.
   localparam logic [2:0] REG_DENSITY_MODE     = 3'd0;
   localparam logic [2:0] REG_TEMPERATURE_MODE = 3'd1;
   localparam logic [2:0] REG_PRESSURE_MODE    = 3'd2;
   localparam logic [2:0] REG_POLYTROPIC_COEFF = 3'd3;
   localparam logic [2:0] REG_DRIFT_SPEED      = 3'd4;
   localparam logic [2:0] REG_ZERO_FLOW        = 3'd5;
   localparam logic [2:0] REG_ION_MASS         = 3'd6;
   localparam logic [2:0] REG_SIDE_ENABLES     = 3'd7;

   // Fixed-point constants.
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [33:0] Q_ONE   = 34'sd65536;

   // Quotient bits of the guard division and the sheath speed division, root bits.
   localparam int GUARD_QUOT_BITS = 31;
   localparam int SPEED_QUOT_BITS = 62;
   localparam int ROOT_BITS       = 31;

   typedef struct packed {
      logic [1:0]         dens_mode;
      logic [1:0]         temp_mode;
      logic [1:0]         pres_mode;
      logic [30:0]        poly;
      logic signed [31:0] drift;
      logic               zero_flow;
      logic [30:0]        mass;
      logic [1:0]         side_en;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dens_mode: MODE_EXP,
      temp_mode: MODE_EXP,
      pres_mode: MODE_EXP,
      poly:      31'd65536,
      drift:     -32'sd65536,
      zero_flow: 1'b0,
      mass:      31'd65536,
      side_en:   2'b11
   };

   typedef struct packed {
      logic               side;
      logic [30:0]        dens_interior;
      logic [30:0]        dens_edge;
      logic signed [31:0] temp_interior;
      logic signed [31:0] temp_edge;
      logic signed [31:0] pres_interior;
      logic signed [31:0] pres_edge;
      logic signed [31:0] vel_edge;
      logic signed [31:0] mom_edge;
   } item_type;

   // Edge values and side information that travel with an item.
   typedef struct packed {
      logic               side;
      logic               en;
      logic [30:0]        n_c;
      logic signed [31:0] t_c;
      logic signed [31:0] p_c;
      logic signed [31:0] v_e;
      logic signed [31:0] nv_e;
   } bnd_type;

   typedef struct packed {
      bnd_type            bnd;
      logic signed [31:0] ng;
      logic signed [31:0] tg;
      logic signed [31:0] pg;
   } guard_type;

   typedef struct packed {
      guard_type          g;
      logic signed [46:0] mn;
      logic [30:0]        s;
   } speed_type;

   typedef struct packed {
      logic signed [31:0] dens_guard;
      logic signed [31:0] temp_guard;
      logic signed [31:0] pres_guard;
      logic signed [31:0] vel_guard;
      logic signed [31:0] mom_guard;
      logic               applied;
   } result_type;

   // Saturate a sign-extended wide value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      if ((v[79:31] == '0) || (v[79:31] == '1)) return v[31:0];
      return v[79] ? S32_MIN : S32_MAX;
   endfunction

endpackage

>>> sv/sbg_guard_pipe.sv
// Guard extrapolation pipeline for density, temperature and pressure with pipelined dividers.
module sbg_guard_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  sbg_pkg::item_type   in_item,
   input  sbg_pkg::cfg_type    cfg,
   output logic                out_valid,
   output sbg_pkg::guard_type  out_guard
);
   localparam int NL = 3;
   localparam int ND = sbg_pkg::GUARD_QUOT_BITS;

   typedef struct packed {
      logic signed [31:0] fix;
      logic               use_div;
      logic               sat;
      logic [30:0]        m;
      logic [30:0]        rem;
      logic [30:0]        lo;
      logic [30:0]        q;
   } lane_div_type;

   // One restoring division step: one quotient bit.
   function automatic lane_div_type div_step(input lane_div_type d);
      lane_div_type r;
      logic [31:0]  t;
      logic         ge;
      r     = d;
      t     = {d.rem, d.lo[30]};
      ge    = (t >= {1'b0, d.m});
      r.rem = ge ? 31'(t - {1'b0, d.m}) : t[30:0];
      r.lo  = {d.lo[29:0], 1'b0};
      r.q   = {d.q[29:0], ge};
      return r;
   endfunction

   function automatic logic signed [31:0] pick(input lane_div_type d);
      if (!d.use_div) return d.fix;
      return d.sat ? sbg_pkg::S32_MAX : $signed({1'b0, d.q});
   endfunction

   logic signed [31:0] m_w    [NL];
   logic signed [31:0] c_w    [NL];
   logic [1:0]         mode_w [NL];
   logic               keep_w [NL];
   logic signed [33:0] lin_w  [NL];
   sbg_pkg::bnd_type   bnd_w;

   logic               vld0_ff, vld1_ff, vf_ff;
   logic [ND:0]        vd_ff;
   sbg_pkg::bnd_type   bnd0_ff, bnd1_ff;
   sbg_pkg::bnd_type   bd_ff [ND+1];
   logic signed [31:0] fix0_ff [NL];
   logic signed [31:0] fix1_ff [NL];
   logic [NL-1:0]      div0_ff, div1_ff;
   logic [31:0]        mag0_ff [NL];
   logic [30:0]        m0_ff   [NL];
   logic [30:0]        m1_ff   [NL];
   logic [62:0]        sq1_ff  [NL];
   lane_div_type       dv_ff   [ND+1][NL];

   // Lane operands and edge values of the incoming item.
   assign m_w[0]    = $signed({1'b0, in_item.dens_interior});
   assign c_w[0]    = $signed({1'b0, in_item.dens_edge});
   assign m_w[1]    = in_item.temp_interior;
   assign c_w[1]    = in_item.temp_edge;
   assign m_w[2]    = in_item.pres_interior;
   assign c_w[2]    = in_item.pres_edge;
   assign mode_w[0] = cfg.dens_mode;
   assign mode_w[1] = cfg.temp_mode;
   assign mode_w[2] = cfg.pres_mode;

   always_comb begin
      bnd_w.side = in_item.side;
      bnd_w.en   = cfg.side_en[in_item.side];
      bnd_w.n_c  = in_item.dens_edge;
      bnd_w.t_c  = in_item.temp_edge;
      bnd_w.p_c  = in_item.pres_edge;
      bnd_w.v_e  = in_item.vel_edge;
      bnd_w.nv_e = in_item.mom_edge;
   end

   // The edge value is kept when the interior is not positive or, in limited mode, below the edge.
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         keep_w[k] = ((mode_w[k] == sbg_pkg::MODE_LIMITED) && (m_w[k] < c_w[k])) ||
                     (m_w[k] <= 32'sd0);
         lin_w[k]  = $signed({c_w[k][31], c_w[k], 1'b0}) -
                     $signed({{2{m_w[k][31]}}, m_w[k]});
      end
   end

   // Valid bits travel beside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vd_ff   <= '0;
         vf_ff   <= 1'b0;
      end else if (adv) begin
         vld0_ff <= in_valid;
         vld1_ff <= vld0_ff;
         vd_ff   <= {vd_ff[ND-1:0], vld1_ff};
         vf_ff   <= vd_ff[ND];
      end
   end

   // Selection, squaring, divider set-up and the division stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         bnd0_ff <= bnd_w;
         bnd1_ff <= bnd0_ff;
         bd_ff[0] <= bnd1_ff;
         for (int i = 1; i <= ND; i++) begin
            bd_ff[i] <= bd_ff[i-1];
         end
         for (int k = 0; k < NL; k++) begin
            fix0_ff[k] <= keep_w[k] ? c_w[k] : sbg_pkg::sat32(80'(lin_w[k]));
            div0_ff[k] <= !keep_w[k] && !mode_w[k][sbg_pkg::LINEAR_BIT];
            mag0_ff[k] <= c_w[k][31] ? (32'(~c_w[k]) + 32'd1) : 32'(c_w[k]);
            m0_ff[k]   <= m_w[k][30:0];
            fix1_ff[k] <= fix0_ff[k];
            div1_ff[k] <= div0_ff[k];
            m1_ff[k]   <= m0_ff[k];
            sq1_ff[k]  <= 63'(64'(mag0_ff[k]) * 64'(mag0_ff[k]));
            dv_ff[0][k].fix     <= fix1_ff[k];
            dv_ff[0][k].use_div <= div1_ff[k];
            dv_ff[0][k].sat     <= (sq1_ff[k][62:31] >= {1'b0, m1_ff[k]});
            dv_ff[0][k].m       <= m1_ff[k];
            dv_ff[0][k].rem     <= sq1_ff[k][61:31];
            dv_ff[0][k].lo      <= sq1_ff[k][30:0];
            dv_ff[0][k].q       <= '0;
            for (int i = 1; i <= ND; i++) begin
               dv_ff[i][k] <= div_step(dv_ff[i-1][k]);
            end
         end
         out_guard.bnd <= bd_ff[ND];
         out_guard.ng  <= pick(dv_ff[ND][0]);
         out_guard.tg  <= pick(dv_ff[ND][1]);
         out_guard.pg  <= pick(dv_ff[ND][2]);
      end
   end

   assign out_valid = vf_ff;

endmodule

>>> sv/sbg_speed_pipe.sv
// Sheath speed pipeline: sheath values, speed division and square root, one bit per stage.
module sbg_speed_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  sbg_pkg::guard_type  in_guard,
   input  sbg_pkg::cfg_type    cfg,
   output logic                out_valid,
   output sbg_pkg::speed_type  out_speed
);
   localparam int ND = sbg_pkg::SPEED_QUOT_BITS;
   localparam int NS = sbg_pkg::ROOT_BITS;

   typedef struct packed {
      sbg_pkg::guard_type g;
      logic signed [46:0] mn;
      logic               sat;
      logic [30:0]        rem;
      logic [61:0]        lo;
      logic [61:0]        q;
   } sdiv_type;

   typedef struct packed {
      sbg_pkg::guard_type g;
      logic signed [46:0] mn;
      logic               sat;
      logic [61:0]        x;
      logic [32:0]        rem;
      logic [30:0]        root;
   } sroot_type;

   function automatic sdiv_type div_step(input sdiv_type d, input logic [30:0] mass);
      sdiv_type    r;
      logic [31:0] t;
      logic        ge;
      r     = d;
      t     = {d.rem, d.lo[61]};
      ge    = (t >= {1'b0, mass});
      r.rem = ge ? 31'(t - {1'b0, mass}) : t[30:0];
      r.lo  = {d.lo[60:0], 1'b0};
      r.q   = {d.q[60:0], ge};
      return r;
   endfunction

   function automatic sroot_type root_step(input sroot_type d);
      sroot_type   r;
      logic [34:0] t;
      logic [32:0] trial;
      logic        ge;
      r      = d;
      t      = {d.rem, d.x[61:60]};
      trial  = {d.root, 2'b01};
      ge     = (t >= {2'b00, trial});
      r.rem  = ge ? 33'(t - {2'b00, trial}) : t[32:0];
      r.root = {d.root[29:0], ge};
      r.x    = {d.x[59:0], 2'b00};
      return r;
   endfunction

   logic [30:0]        mass_w;
   logic signed [32:0] nsum_w, tsum_w;
   logic signed [31:0] thalf_w;

   logic               va_ff, vb_ff;
   logic [ND:0]        vd_ff;
   logic [NS:0]        vs_ff;
   sbg_pkg::guard_type ga_ff, gb_ff;
   logic signed [31:0] nsh_a_ff;
   logic [30:0]        tsh_a_ff;
   logic [62:0]        prod_b_ff;
   logic signed [63:0] mnf_b_ff;
   sdiv_type           dv_ff [ND+1];
   sroot_type          sr_ff [NS+1];

   // A zero mass acts as the smallest step.
   assign mass_w  = (cfg.mass == '0) ? 31'd1 : cfg.mass;

   // Sheath density and temperature: halved sums, temperature floored to one step.
   assign nsum_w  = $signed({in_guard.ng[31], in_guard.ng}) + $signed({2'b00, in_guard.bnd.n_c});
   assign tsum_w  = $signed({in_guard.tg[31], in_guard.tg}) +
                    $signed({in_guard.bnd.t_c[31], in_guard.bnd.t_c});
   assign thalf_w = tsum_w[32:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vd_ff <= '0;
         vs_ff <= '0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vd_ff <= {vd_ff[ND-1:0], vb_ff};
         vs_ff <= {vs_ff[NS-1:0], vd_ff[ND]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ga_ff    <= in_guard;
         nsh_a_ff <= nsum_w[32:1];
         tsh_a_ff <= (thalf_w < 32'sd1) ? 31'd1 : thalf_w[30:0];

         // Products: twice polytropic times temperature, and mass times density.
         gb_ff     <= ga_ff;
         prod_b_ff <= {62'(cfg.poly) * 62'(tsh_a_ff), 1'b0};
         mnf_b_ff  <= $signed({1'b0, mass_w}) * nsh_a_ff;

         // Divider set-up: the speed saturates when the integer quotient is too large.
         dv_ff[0].g   <= gb_ff;
         dv_ff[0].mn  <= mnf_b_ff[62:16];
         dv_ff[0].sat <= ({14'd0, prod_b_ff[62:46]} >= mass_w);
         dv_ff[0].rem <= {14'd0, prod_b_ff[62:46]};
         dv_ff[0].lo  <= {prod_b_ff[45:0], 16'd0};
         dv_ff[0].q   <= '0;
         for (int i = 1; i <= ND; i++) begin
            dv_ff[i] <= div_step(dv_ff[i-1], mass_w);
         end

         // Square root, one result bit per stage.
         sr_ff[0].g    <= dv_ff[ND].g;
         sr_ff[0].mn   <= dv_ff[ND].mn;
         sr_ff[0].sat  <= dv_ff[ND].sat;
         sr_ff[0].x    <= dv_ff[ND].q;
         sr_ff[0].rem  <= '0;
         sr_ff[0].root <= '0;
         for (int i = 1; i <= NS; i++) begin
            sr_ff[i] <= root_step(sr_ff[i-1]);
         end
      end
   end

   assign out_valid   = vs_ff[NS];
   assign out_speed.g  = sr_ff[NS].g;
   assign out_speed.mn = sr_ff[NS].mn;
   assign out_speed.s  = sr_ff[NS].sat ? '1 : sr_ff[NS].root;

endmodule

>>> sv/sbg_reflect.sv
// Sheath velocity, drift scaling, flow clamp and reflection of velocity and momentum.
module sbg_reflect (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  sbg_pkg::speed_type  in_speed,
   input  sbg_pkg::cfg_type    cfg,
   output logic                out_valid,
   output sbg_pkg::result_type out_result
);
   logic signed [31:0] v0_w;
   logic signed [33:0] fac_w;
   logic signed [31:0] vd_w, vc_w;

   logic [4:0]         v_ff;
   sbg_pkg::speed_type s1_ff, s2_ff, s3_ff, s4_ff;
   logic signed [31:0] v0_1_ff;
   logic signed [65:0] vf_1_ff;
   logic               drift_1_ff;
   logic signed [31:0] v_2_ff;
   logic signed [31:0] vg_3_ff, vg_4_ff;
   logic signed [62:0] pph_3_ff;
   logic signed [48:0] ppl_3_ff;
   logic signed [79:0] p_4_ff;

   // Signed sheath speed and drift factor for the side.
   assign v0_w  = in_speed.g.bnd.side ? $signed({1'b0, in_speed.s}) : -$signed({1'b0, in_speed.s});
   assign fac_w = in_speed.g.bnd.side ? (sbg_pkg::Q_ONE - 34'(cfg.drift))
                                      : (sbg_pkg::Q_ONE + 34'(cfg.drift));

   // Drift result, then clamp by the edge flow, then no-flow override.
   always_comb begin
      vd_w = drift_1_ff ? sbg_pkg::sat32(80'(vf_1_ff >>> 16)) : v0_1_ff;
      vc_w = vd_w;
      if (!s1_ff.g.bnd.side && (s1_ff.g.bnd.v_e < vd_w)) vc_w = s1_ff.g.bnd.v_e;
      if (s1_ff.g.bnd.side && (s1_ff.g.bnd.v_e > vd_w)) vc_w = s1_ff.g.bnd.v_e;
      if (cfg.zero_flow) vc_w = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff      <= in_speed;
         v0_1_ff    <= v0_w;
         vf_1_ff    <= v0_w * fac_w;
         drift_1_ff <= (cfg.drift > 32'sd0);

         s2_ff  <= s1_ff;
         v_2_ff <= vc_w;

         // Momentum partial products: upper and lower parts of mass times density.
         s3_ff    <= s2_ff;
         vg_3_ff  <= sbg_pkg::sat32(80'($signed({v_2_ff[31], v_2_ff, 1'b0}) -
                     $signed({{2{s2_ff.g.bnd.v_e[31]}}, s2_ff.g.bnd.v_e})));
         pph_3_ff <= $signed(s2_ff.mn[46:16]) * v_2_ff;
         ppl_3_ff <= $signed({1'b0, s2_ff.mn[15:0]}) * v_2_ff;

         s4_ff   <= s3_ff;
         vg_4_ff <= vg_3_ff;
         p_4_ff  <= (80'(pph_3_ff) <<< 16) + 80'(ppl_3_ff);

         // Output register: a disabled side passes the edge values.
         out_result.applied <= s4_ff.g.bnd.en;
         if (s4_ff.g.bnd.en) begin
            out_result.dens_guard <= s4_ff.g.ng;
            out_result.temp_guard <= s4_ff.g.tg;
            out_result.pres_guard <= s4_ff.g.pg;
            out_result.vel_guard  <= vg_4_ff;
            out_result.mom_guard  <= sbg_pkg::sat32((p_4_ff >>> 15) - 80'(s4_ff.g.bnd.nv_e));
         end else begin
            out_result.dens_guard <= $signed({1'b0, s4_ff.g.bnd.n_c});
            out_result.temp_guard <= s4_ff.g.bnd.t_c;
            out_result.pres_guard <= s4_ff.g.bnd.p_c;
            out_result.vel_guard  <= s4_ff.g.bnd.v_e;
            out_result.mom_guard  <= s4_ff.g.bnd.nv_e;
         end
      end
   end

   assign out_valid = v_ff[4];

endmodule

>>> sv/sheath_boundary_guard_cell.sv
// Top level of the sheath boundary guard cell: configuration registers, stream ports, pipeline.
//
// One boundary cell enters per clock and the guard values leave in the order the cells were
// accepted; the whole path is a single pipeline that stalls as one when a result is waiting and
// rsp_tready is low. The depth is set by the 31-stage guard divider, the 62-stage sheath speed
// divider and the 31-stage square root, each resolving one bit per stage. Configuration writes
// take effect at once and are meant for times when no item is in flight.
module sheath_boundary_guard_cell (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dens_interior, dens_edge, temp_interior, temp_edge, pres_interior, pres_edge,
   // vel_edge, mom_edge, from bit 0 up; two zero bits on top.
   input  logic [255:0] req_tdata,
   // side
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // dens_guard, temp_guard, pres_guard, vel_guard, mom_guard, from bit 0 up.
   output logic [159:0] rsp_tdata,
   // applied
   output logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   sbg_pkg::cfg_type    cfg_ff;
   sbg_pkg::item_type   item_w;
   sbg_pkg::guard_type  guard_w;
   sbg_pkg::speed_type  speed_w;
   sbg_pkg::result_type result_w;
   logic                adv;
   logic                gvalid_w, svalid_w;

   // The pipeline moves whenever the output register is free or being emptied.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sbg_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sbg_pkg::REG_DENSITY_MODE:     cfg_ff.dens_mode <= csr_wdata[1:0];
            sbg_pkg::REG_TEMPERATURE_MODE: cfg_ff.temp_mode <= csr_wdata[1:0];
            sbg_pkg::REG_PRESSURE_MODE:    cfg_ff.pres_mode <= csr_wdata[1:0];
            sbg_pkg::REG_POLYTROPIC_COEFF: cfg_ff.poly      <= csr_wdata[30:0];
            sbg_pkg::REG_DRIFT_SPEED:      cfg_ff.drift     <= $signed(csr_wdata);
            sbg_pkg::REG_ZERO_FLOW:        cfg_ff.zero_flow <= csr_wdata[0];
            sbg_pkg::REG_ION_MASS:         cfg_ff.mass      <= csr_wdata[30:0];
            sbg_pkg::REG_SIDE_ENABLES:     cfg_ff.side_en   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Unpack the input item.
   always_comb begin
      item_w.side          = req_tuser[0];
      item_w.dens_interior = req_tdata[30:0];
      item_w.dens_edge     = req_tdata[61:31];
      item_w.temp_interior = $signed(req_tdata[93:62]);
      item_w.temp_edge     = $signed(req_tdata[125:94]);
      item_w.pres_interior = $signed(req_tdata[157:126]);
      item_w.pres_edge     = $signed(req_tdata[189:158]);
      item_w.vel_edge      = $signed(req_tdata[221:190]);
      item_w.mom_edge      = $signed(req_tdata[253:222]);
   end

   sbg_guard_pipe u_guard (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_item   (item_w),
      .cfg       (cfg_ff),
      .out_valid (gvalid_w),
      .out_guard (guard_w)
   );

   sbg_speed_pipe u_speed (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (gvalid_w),
      .in_guard  (guard_w),
      .cfg       (cfg_ff),
      .out_valid (svalid_w),
      .out_speed (speed_w)
   );

   sbg_reflect u_reflect (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (svalid_w),
      .in_speed   (speed_w),
      .cfg        (cfg_ff),
      .out_valid  (rsp_tvalid),
      .out_result (result_w)
   );

   // Pack the result item.
   assign rsp_tdata = {result_w.mom_guard, result_w.vel_guard, result_w.pres_guard,
                       result_w.temp_guard, result_w.dens_guard};
   assign rsp_tuser = result_w.applied;

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Input is refused only while a finished result waits.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input refused without a waiting result");

   // A waiting result blocks the input side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while the output is stalled");

endmodule

>>> dv/tb_sheath_boundary_guard_cell.sv
// Self-checking testbench of the sheath boundary guard cell with its own guard value predictor.
module tb_sheath_boundary_guard_cell;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;

   sheath_boundary_guard_cell dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Copy of the configuration as the block should hold it.
   sbg_pkg::cfg_type    guard_cfg = sbg_pkg::CFG_RESET;
   sbg_pkg::result_type guard_results_due[$];
   int         sender_idle_pct;
   int         receiver_idle_pct;
   int         mismatches;
   int         cells_sent;
   int         cells_checked;
   int         cfg_writes;

   // Clock and the run limit.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #40_000_000;
      $display("sheath_boundary_guard_cell: mismatch");
      $finish;
   end

   // Clip a wide signed value to the 32-bit range.
   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Guard value from the interior value m and the edge value c.
   function automatic longint guard_extrap(input longint m, input longint c,
                                           input logic [1:0] mode);
      longint unsigned mag;
      longint unsigned q;
      if (mode == sbg_pkg::MODE_LIMITED && m < c) return c;
      if (m <= 0) return c;
      if (mode[sbg_pkg::LINEAR_BIT]) return clip32(2 * c - m);
      mag = (c < 0) ? longint'(-c) : longint'(c);
      q = (mag * mag) / longint'(m);
      return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
   endfunction

   // Expected guard values of one boundary cell under the current configuration.
   function automatic sbg_pkg::result_type predict_guard(input sbg_pkg::item_type it);
      sbg_pkg::result_type res;
      longint          n_c, t_c, p_c, v_e, nv_e, ng, tg, pg, nsh, tsh, mass, drift;
      longint          v, mn, p, vg;
      longint unsigned prod, q, r, s, am, av;
      n_c  = longint'(it.dens_edge);
      t_c  = longint'(it.temp_edge);
      p_c  = longint'(it.pres_edge);
      v_e  = longint'(it.vel_edge);
      nv_e = longint'(it.mom_edge);
      if (guard_cfg.side_en[it.side] == 1'b0) begin
         res.dens_guard = n_c[31:0];
         res.temp_guard = it.temp_edge;
         res.pres_guard = it.pres_edge;
         res.vel_guard  = it.vel_edge;
         res.mom_guard  = it.mom_edge;
         res.applied    = 1'b0;
         return res;
      end
      ng = guard_extrap(longint'(it.dens_interior), n_c, guard_cfg.dens_mode);
      tg = guard_extrap(longint'(it.temp_interior), t_c, guard_cfg.temp_mode);
      pg = guard_extrap(longint'(it.pres_interior), p_c, guard_cfg.pres_mode);
      nsh = (ng + n_c) >>> 1;
      tsh = (tg + t_c) >>> 1;
      if (tsh < 1) tsh = 1;

      // Sheath speed from the floored sheath temperature.
      mass = (guard_cfg.mass == 0) ? 64'sd1 : longint'(guard_cfg.mass);
      prod = 64'd2 * longint'(guard_cfg.poly) * tsh;
      q = prod / mass;
      r = prod % mass;
      if (q >= (64'd1 << 46)) begin
         s = 64'd2147483647;
      end else begin
         s = int_sqrt((q << 16) + ((r << 16) / mass));
         if (s > 64'd2147483647) s = 64'd2147483647;
      end

      // Drift scaling, clamp by the edge flow and the zero-flow override.
      v = it.side ? longint'(s) : -longint'(s);
      drift = longint'(guard_cfg.drift);
      if (drift > 0) v = clip32((v * (it.side ? (65536 - drift) : (65536 + drift))) >>> 16);
      if (!it.side && v_e < v) v = v_e;
      if (it.side && v_e > v) v = v_e;
      if (guard_cfg.zero_flow) v = 0;

      mn = (mass * nsh) >>> 16;
      am = (mn < 0) ? longint'(-mn) : longint'(mn);
      av = (v < 0) ? longint'(-v) : longint'(v);
      if (av != 0 && am > ((64'd1 << 62) / av)) begin
         p = ((mn < 0) != (v < 0)) ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
         p = longint'(am * av);
         if ((mn < 0) != (v < 0)) p = -p;
         p = clip32((p >>> 15) - nv_e);
      end
      vg = clip32(2 * v - v_e);

      res.dens_guard = ng[31:0];
      res.temp_guard = tg[31:0];
      res.pres_guard = pg[31:0];
      res.vel_guard  = vg[31:0];
      res.mom_guard  = p[31:0];
      res.applied    = 1'b1;
      return res;
   endfunction

   // Result side: random back-pressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      sbg_pkg::result_type want;
      logic [31:0] got_word;
      logic [31:0] want_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (guard_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item: %h", rsp_tdata);
         end else begin
            want = guard_results_due.pop_front();
            cells_checked++;
            for (int k = 0; k < 6; k++) begin
               case (k)
                  0: want_word = want.dens_guard;
                  1: want_word = want.temp_guard;
                  2: want_word = want.pres_guard;
                  3: want_word = want.vel_guard;
                  4: want_word = want.mom_guard;
                  default: want_word = {31'd0, want.applied};
               endcase
               got_word = (k < 5) ? rsp_tdata[32*k +: 32] : {31'd0, rsp_tuser[0]};
               if (got_word !== want_word) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d field %0d: expected %h, got %h",
                              cells_checked, k, want_word, got_word);
               end
            end
         end
      end
   end

   // Send one boundary cell and record its expected result at the handshake.
   task automatic send_cell(input sbg_pkg::item_type it);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.side;
      req_tdata  <= {2'b00, it.mom_edge, it.vel_edge, it.pres_edge, it.pres_interior,
                     it.temp_edge, it.temp_interior, it.dens_edge, it.dens_interior};
      do @(posedge clock); while (!req_tready);
      guard_results_due.push_back(predict_guard(it));
      cells_sent++;
      @(negedge clock);
   endtask

   // Let the pipeline empty before the configuration may change.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (guard_results_due.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         sbg_pkg::REG_DENSITY_MODE:     guard_cfg.dens_mode = value[1:0];
         sbg_pkg::REG_TEMPERATURE_MODE: guard_cfg.temp_mode = value[1:0];
         sbg_pkg::REG_PRESSURE_MODE:    guard_cfg.pres_mode = value[1:0];
         sbg_pkg::REG_POLYTROPIC_COEFF: guard_cfg.poly      = value[30:0];
         sbg_pkg::REG_DRIFT_SPEED:      guard_cfg.drift     = value;
         sbg_pkg::REG_ZERO_FLOW:        guard_cfg.zero_flow = value[0];
         sbg_pkg::REG_ION_MASS:         guard_cfg.mass      = value[30:0];
         sbg_pkg::REG_SIDE_ENABLES:     guard_cfg.side_en   = value[1:0];
         default: ;
      endcase
      cfg_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'($urandom_range(0, 32'h3F_FFFF)) - 32'h20_0000;
         default: return $urandom();
      endcase
   endfunction

   // A plausible cell: positive edge values with the interior close to the edge; or pure noise.
   function automatic sbg_pkg::item_type make_cell(input bit plausible);
      sbg_pkg::item_type it;
      logic [31:0] base;
      logic [31:0] word;
      it.side = 1'($urandom_range(0, 1));
      if (plausible) begin
         base = $urandom_range(1, 32'h00FF_FFFF);
         it.dens_edge     = base[30:0];
         it.dens_interior = 31'(base + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000);
         base = $urandom_range(1, 32'h00FF_FFFF);
         it.temp_edge     = base;
         it.temp_interior = base + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         base = $urandom_range(1, 32'h00FF_FFFF);
         it.pres_edge     = base;
         it.pres_interior = base + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         it.vel_edge      = $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000;
         it.mom_edge      = $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000;
      end else begin
         word = pick_word();
         it.dens_interior = word[30:0];
         word = pick_word();
         it.dens_edge     = word[30:0];
         it.temp_interior = pick_word();
         it.temp_edge     = pick_word();
         it.pres_interior = pick_word();
         it.pres_edge     = pick_word();
         it.vel_edge      = pick_word();
         it.mom_edge      = pick_word();
      end
      return it;
   endfunction

   // Cells under the reset configuration.
   task automatic test_reset_config();
      repeat (4) send_cell(make_cell(1'b1));
      drain_pipeline();
   endtask

   // Field extremes, every mode including code three, disabled sides, zero mass and drift.
   task automatic test_directed();
      sbg_pkg::item_type it;
      it = '{side: 1'b0, dens_interior: 31'h7FFF_FFFF, dens_edge: 31'h7FFF_FFFF,
             temp_interior: sbg_pkg::S32_MAX, temp_edge: sbg_pkg::S32_MAX,
             pres_interior: sbg_pkg::S32_MIN, pres_edge: sbg_pkg::S32_MIN,
             vel_edge: sbg_pkg::S32_MIN, mom_edge: sbg_pkg::S32_MAX};
      send_cell(it);
      it.side = 1'b1;
      send_cell(it);
      it = '{side: 1'b1, dens_interior: 31'd0, dens_edge: 31'd0, temp_interior: 32'sd0,
             temp_edge: 32'sd0, pres_interior: 32'sd0, pres_edge: 32'sd0,
             vel_edge: sbg_pkg::S32_MAX, mom_edge: sbg_pkg::S32_MIN};
      send_cell(it);
      drain_pipeline();
      for (int mode = 0; mode < 4; mode++) begin
         write_reg(sbg_pkg::REG_DENSITY_MODE, mode);
         write_reg(sbg_pkg::REG_TEMPERATURE_MODE, mode);
         write_reg(sbg_pkg::REG_PRESSURE_MODE, 3 - mode);
         repeat (3) send_cell(make_cell(1'b1));
         drain_pipeline();
      end
      for (int en = 0; en < 3; en++) begin
         write_reg(sbg_pkg::REG_SIDE_ENABLES, en);
         send_cell(make_cell(1'b0));
         send_cell(make_cell(1'b1));
         drain_pipeline();
      end
      write_reg(sbg_pkg::REG_SIDE_ENABLES, 3);
      write_reg(sbg_pkg::REG_ION_MASS, 0);
      write_reg(sbg_pkg::REG_DRIFT_SPEED, 32'h0000_8000);
      write_reg(sbg_pkg::REG_POLYTROPIC_COEFF, 32'h7FFF_FFFF);
      send_cell(make_cell(1'b1));
      send_cell(make_cell(1'b0));
      drain_pipeline();
      write_reg(sbg_pkg::REG_ZERO_FLOW, 1);
      write_reg(sbg_pkg::REG_ION_MASS, 32'h7FFF_FFFF);
      write_reg(sbg_pkg::REG_DRIFT_SPEED, 32'h7FFF_FFFF);
      write_reg(sbg_pkg::REG_POLYTROPIC_COEFF, 0);
      send_cell(make_cell(1'b1));
      drain_pipeline();
   endtask

   // Random cells under random settings, in the given idling pattern.
   task automatic test_random(input int send_pct, input int recv_pct, input int count);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 110 == 0) begin
            drain_pipeline();
            write_reg(sbg_pkg::REG_DENSITY_MODE, $urandom_range(0, 3));
            write_reg(sbg_pkg::REG_TEMPERATURE_MODE, $urandom_range(0, 3));
            write_reg(sbg_pkg::REG_PRESSURE_MODE, $urandom_range(0, 3));
            write_reg(sbg_pkg::REG_POLYTROPIC_COEFF, ($urandom_range(0, 3) == 0) ? $urandom()
                                                     : $urandom_range(1, 32'h8_0000));
            write_reg(sbg_pkg::REG_DRIFT_SPEED, ($urandom_range(0, 1) == 0) ? $urandom()
                                                : $urandom_range(0, 32'h1_FFFF) - 32'h1_0000);
            write_reg(sbg_pkg::REG_ZERO_FLOW,
                      ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : 32'd0);
            write_reg(sbg_pkg::REG_ION_MASS, ($urandom_range(0, 3) == 0) ? $urandom()
                                             : $urandom_range(1, 32'h8_0000));
            write_reg(sbg_pkg::REG_SIDE_ENABLES,
                      ($urandom_range(0, 3) == 0) ? $urandom() : 32'd3);
         end
         send_cell(make_cell($urandom_range(0, 3) != 0));
      end
      drain_pipeline();
   endtask

   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tuser         = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      mismatches        = 0;
      cells_sent        = 0;
      cells_checked     = 0;
      cfg_writes        = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_config();
      test_directed();
      test_random(23, 80, 670);
      test_random(80, 23, 670);
      test_random(0, 0, 670);

      $display("Sent %0d boundary cells and checked %0d results over %0d register writes,",
               cells_sent, cells_checked, cfg_writes);
      $display("covering all modes, both sides, disabled sides and stalls on both ports.");
      if (mismatches == 0) begin
         $display("sheath_boundary_guard_cell: match");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("sheath_boundary_guard_cell: mismatch");
      end
      $finish;
   end

endmodule
